FILE: rtl/core/ptmr_pkg.sv
// Shared types, register map and field constants for the up-counting PWM timer.
`default_nettype none

package ptmr_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int STATUS_W     = 5;
  localparam int IRQ_EN_W     = 5;
  localparam int CTRL_W       = 8;

  // Control register bits.
  localparam int CTRL_ENABLE_BIT  = 0;
  localparam int CTRL_PRELOAD_BIT = 7;

  // Status and interrupt-enable layout: bit 0 is the update flag, bit c+1 is channel c.
  localparam int STAT_UPDATE_BIT = 0;

  // Per-channel mode byte layout.
  localparam int MODE_PRELOAD_BIT = 3;
  localparam int MODE_LSB         = 4;
  localparam int MODE_MSB         = 6;
  localparam logic [2:0] MODE_PWM1 = 3'd6;
  localparam logic [2:0] MODE_PWM2 = 3'd7;

  // Output enable register: bit 4c enables channel c, bit 4c+1 selects active-low.
  localparam int OE_STRIDE       = 4;
  localparam int OE_POLARITY_OFS = 1;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    REG_CTRL     = 4'd0,
    REG_IRQ_EN   = 4'd1,
    REG_STATUS   = 4'd2,
    REG_MODE0    = 4'd3,
    REG_MODE1    = 4'd4,
    REG_OUT_EN   = 4'd5,
    REG_COUNT    = 4'd6,
    REG_PRESCALE = 4'd7,
    REG_RELOAD   = 4'd8,
    REG_CMP0     = 4'd9,
    REG_CMP1     = 4'd10,
    REG_CMP2     = 4'd11,
    REG_CMP3     = 4'd12
  } reg_idx_t;

  typedef struct packed {
    action_t     action;
    reg_idx_t    reg_index;
    logic [15:0] write_data;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  pwm_level;
    logic        irq;
  } result_t;

  typedef logic [1:0][15:0] mode_words_t;

  // Mode byte of one channel: channel c lives in byte c%2 of word c/2.
  function automatic logic [7:0] chan_cfg(input mode_words_t modes, input logic [1:0] ch);
    logic [15:0] word;
    word = modes[ch[1]];
    return ch[0] ? word[15:8] : word[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ptmr_regs.sv
// Register file and counting state of the timer, with next-state and read logic.
`default_nettype none

module ptmr_regs import ptmr_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire item_t                  item,
  output logic [15:0]                 read_data,
  output logic                        irq_next,
  output logic [COUNT_WIDTH-1:0]      count_next,
  output logic [COUNT_WIDTH-1:0]      cmp_act_next [CHANNELS],
  output mode_words_t                 modes_next,
  output logic [15:0]                 oe_next
);

  logic [COUNT_WIDTH-1:0] count;
  logic [15:0]            psc_cnt;
  logic [15:0]            psc_reg;
  logic [15:0]            psc_act;
  logic [COUNT_WIDTH-1:0] rld_reg;
  logic [COUNT_WIDTH-1:0] rld_act;
  logic [COUNT_WIDTH-1:0] cmp_reg [CHANNELS];
  logic [COUNT_WIDTH-1:0] cmp_act [CHANNELS];
  logic [CTRL_W-1:0]      ctrl;
  logic [IRQ_EN_W-1:0]    irq_en;
  logic [STATUS_W-1:0]    status;
  mode_words_t            modes;
  logic [15:0]            oe;

  logic [15:0]            psc_cnt_next;
  logic [15:0]            psc_reg_next;
  logic [15:0]            psc_act_next;
  logic [COUNT_WIDTH-1:0] rld_reg_next;
  logic [COUNT_WIDTH-1:0] rld_act_next;
  logic [COUNT_WIDTH-1:0] cmp_reg_next [CHANNELS];
  logic [CTRL_W-1:0]      ctrl_next;
  logic [IRQ_EN_W-1:0]    irq_en_next;
  logic [STATUS_W-1:0]    status_next;
  logic [COUNT_WIDTH-1:0] wr_count;
  logic [7:0]             cfg_byte;

  assign wr_count = COUNT_WIDTH'(item.write_data);

  always_comb begin
    count_next   = count;
    psc_cnt_next = psc_cnt;
    psc_reg_next = psc_reg;
    psc_act_next = psc_act;
    rld_reg_next = rld_reg;
    rld_act_next = rld_act;
    ctrl_next    = ctrl;
    irq_en_next  = irq_en;
    status_next  = status;
    modes_next   = modes;
    oe_next      = oe;
    cfg_byte     = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      cmp_reg_next[c] = cmp_reg[c];
      cmp_act_next[c] = cmp_act[c];
    end

    if (step) begin
      unique case (item.action)
        ACT_TICK: begin
          if (ctrl[CTRL_ENABLE_BIT]) begin
            if (psc_cnt != psc_act) begin
              psc_cnt_next = psc_cnt + 16'd1;
            end else begin
              psc_cnt_next = '0;
              if (count == rld_act) begin
                // Update event: wrap and move the preloaded values into use.
                count_next                   = '0;
                status_next[STAT_UPDATE_BIT] = 1'b1;
                psc_act_next                 = psc_reg;
                rld_act_next                 = rld_reg;
                for (int c = 0; c < CHANNELS; c++) begin
                  cmp_act_next[c] = cmp_reg[c];
                end
              end else begin
                count_next = count + COUNT_WIDTH'(1);
              end
              for (int c = 0; c < CHANNELS; c++) begin
                if (count_next == cmp_act_next[c]) begin
                  status_next[c+1] = 1'b1;
                end
              end
            end
          end
        end
        ACT_WRITE: begin
          unique case (item.reg_index) inside
            REG_CTRL:     ctrl_next    = item.write_data[CTRL_W-1:0];
            REG_IRQ_EN:   irq_en_next  = item.write_data[IRQ_EN_W-1:0];
            REG_STATUS:   status_next  = status & item.write_data[STATUS_W-1:0];
            REG_MODE0:    modes_next[0] = item.write_data;
            REG_MODE1:    modes_next[1] = item.write_data;
            REG_OUT_EN:   oe_next      = item.write_data;
            REG_COUNT:    count_next   = wr_count;
            REG_PRESCALE: psc_reg_next = item.write_data;
            REG_RELOAD: begin
              rld_reg_next = wr_count;
              if (!ctrl[CTRL_PRELOAD_BIT]) begin
                rld_act_next = wr_count;
              end
            end
            [REG_CMP0:REG_CMP3]: begin
              for (int c = 0; c < CHANNELS; c++) begin
                if (4'(item.reg_index) == 4'(REG_CMP0) + 4'(c)) begin
                  cmp_reg_next[c] = wr_count;
                  cfg_byte = chan_cfg(modes, 2'(c));
                  if (!cfg_byte[MODE_PRELOAD_BIT]) begin
                    cmp_act_next[c] = wr_count;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        ACT_READ: ;
        default: ;
      endcase
    end
  end

  assign irq_next = |(status_next & irq_en_next);

  // Reads never change state, so they look at the current registers.
  always_comb begin
    read_data = '0;
    if (item.action == ACT_READ) begin
      unique case (item.reg_index) inside
        REG_CTRL:     read_data = 16'(ctrl);
        REG_IRQ_EN:   read_data = 16'(irq_en);
        REG_STATUS:   read_data = 16'(status);
        REG_MODE0:    read_data = modes[0];
        REG_MODE1:    read_data = modes[1];
        REG_OUT_EN:   read_data = oe;
        REG_COUNT:    read_data = 16'(count);
        REG_PRESCALE: read_data = psc_reg;
        REG_RELOAD:   read_data = 16'(rld_reg);
        [REG_CMP0:REG_CMP3]: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (4'(item.reg_index) == 4'(REG_CMP0) + 4'(c)) begin
              read_data = 16'(cmp_reg[c]);
            end
          end
        end
        default: read_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      psc_cnt <= '0;
      psc_reg <= '0;
      psc_act <= '0;
      rld_reg <= '1;
      rld_act <= '1;
      ctrl    <= '0;
      irq_en  <= '0;
      status  <= '0;
      modes   <= '0;
      oe      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        cmp_reg[c] <= '0;
        cmp_act[c] <= '0;
      end
    end else if (step) begin
      count   <= count_next;
      psc_cnt <= psc_cnt_next;
      psc_reg <= psc_reg_next;
      psc_act <= psc_act_next;
      rld_reg <= rld_reg_next;
      rld_act <= rld_act_next;
      ctrl    <= ctrl_next;
      irq_en  <= irq_en_next;
      status  <= status_next;
      modes   <= modes_next;
      oe      <= oe_next;
      for (int c = 0; c < CHANNELS; c++) begin
        cmp_reg[c] <= cmp_reg_next[c];
        cmp_act[c] <= cmp_act_next[c];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ptmr_pwm.sv
// PWM output levels of all channels from counter, active compares, modes and enables.
`default_nettype none

module ptmr_pwm import ptmr_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic [COUNT_WIDTH-1:0] count,
  input  wire logic [COUNT_WIDTH-1:0] cmp_act [CHANNELS],
  input  wire mode_words_t            modes,
  input  wire logic [15:0]            oe,
  output logic [MAX_CHANNELS-1:0]     level
);

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_chan
    if (c < CHANNELS) begin : g_used
      logic [7:0] cfg;
      logic [2:0] mode;
      logic       below;
      logic       active;

      assign cfg   = chan_cfg(modes, 2'(c));
      assign mode  = cfg[MODE_MSB:MODE_LSB];
      assign below = count < cmp_act[c];

      always_comb begin
        case (mode)
          MODE_PWM1: active = below;
          MODE_PWM2: active = !below;
          default:   active = 1'b0;
        endcase
      end

      assign level[c] = oe[OE_STRIDE*c] & (active ^ oe[OE_STRIDE*c + OE_POLARITY_OFS]);
    end else begin : g_unused
      assign level[c] = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/up_counting_pwm_timer.sv
// Top level of the up-counting PWM timer: transaction staging and result register.
// This block is a 16-bit up-counting timer with PWM channels, driven entirely by
// transactions on its item channel. Each transaction is a clock tick, a register write or a
// register read, and each one produces exactly one result transaction carrying the read data
// (zero unless the transaction was a read), the PWM levels and the interrupt line as they stand
// after that transaction. A tick advances the prescaler; when the prescaler wraps, the counter
// steps, and a counter equal to the active reload value returns to zero, sets the update flag
// and loads the preloaded prescale, reload and compare values. A counter step that lands on a
// channel's active compare value sets that channel's status flag. Writing the status register
// keeps only the bits written as one. Transactions pass through an input register,
// combinational logic that updates the timer state and forms the result, and a result
// register, so a new transaction is taken every clock cycle while the result register is
// not held by a stalled consumer; a result is loaded when its staged transaction advances.
// Each transaction updates the timer state before the next one can use it. When the result
// register is held by a stalled consumer, the input register still takes one more transaction
// before item_ready drops.
`default_nettype none

module up_counting_pwm_timer import ptmr_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  item_t                  item_q;
  logic                   item_q_valid;
  logic                   advance;
  logic [15:0]            read_data;
  logic                   irq_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] cmp_act_next [CHANNELS];
  mode_words_t            modes_next;
  logic [15:0]            oe_next;
  logic [MAX_CHANNELS-1:0] level;

  // The staged transaction is processed when the result register is free or being emptied.
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  ptmr_regs #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .item         (item_q),
    .read_data    (read_data),
    .irq_next     (irq_next),
    .count_next   (count_next),
    .cmp_act_next (cmp_act_next),
    .modes_next   (modes_next),
    .oe_next      (oe_next)
  );

  // Levels are taken from the state as it will be after this transaction.
  ptmr_pwm #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pwm (
    .count   (count_next),
    .cmp_act (cmp_act_next),
    .modes   (modes_next),
    .oe      (oe_next),
    .level   (level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.read_data <= read_data;
      result.pwm_level <= level;
      result.irq       <= irq_next;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the up-counting PWM timer: driver, predictor and result checker.
module tb_top;
  import ptmr_pkg::*;

  // Action code 3 is outside the package enum; the timer must treat it as a no-op.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  always #10 clk = ~clk;

  up_counting_pwm_timer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Transactions waiting to be offered, and the results predicted for accepted ones.
  item_t   pending_items[$];
  result_t predicted_results[$];

  int items_offered = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int fail_count = 0;
  int update_events = 0;
  int compare_hits = 0;
  int longest_ready_hold = 0;

  // ---------------------------------------------------------------------------
  // Timer model. These mirror the block's registers and its active (shadow)
  // copies. The reset values match the block: everything clears, except the
  // reload register and its active copy, which come up all ones.
  // ---------------------------------------------------------------------------
  logic [15:0] t_count = '0;
  logic [15:0] t_psc_count = '0;
  logic [15:0] t_psc_reg = '0;
  logic [15:0] t_psc_act = '0;
  logic [15:0] t_reload_reg = 16'hFFFF;
  logic [15:0] t_reload_act = 16'hFFFF;
  logic [15:0] t_cmp_reg [MAX_CHANNELS] = '{default: '0};
  logic [15:0] t_cmp_act [MAX_CHANNELS] = '{default: '0};
  logic [CTRL_W-1:0]   t_ctrl = '0;
  logic [IRQ_EN_W-1:0] t_irq_en = '0;
  logic [STATUS_W-1:0] t_status = '0;
  logic [15:0] t_mode [2] = '{default: '0};
  logic [15:0] t_out_en = '0;

  // Each mode word holds two channels, one per byte: the even channel sits in
  // the low byte.
  function automatic logic [7:0] channel_cfg(input int c);
    return (c % 2) ? t_mode[c / 2][15:8] : t_mode[c / 2][7:0];
  endfunction

  // Apply one transaction to the model and return what the block must report.
  task automatic timer_step(input item_t it, output result_t res);
    int c;
    logic [7:0] cfg;
    logic [2:0] mode;
    logic below, active;
    logic [15:0] rd;
    logic [3:0] lv;
    rd = '0;
    lv = '0;
    case (it.action)
      ACT_TICK: begin
        // With the counter disabled, a tick leaves every piece of state alone.
        if (t_ctrl[CTRL_ENABLE_BIT]) begin
          if (t_psc_count != t_psc_act) begin
            t_psc_count = t_psc_count + 16'd1;
          end else begin
            t_psc_count = '0;
            if (t_count == t_reload_act) begin
              // Update event: wrap to zero and pull in all the preloaded values.
              t_count = '0;
              t_status[STAT_UPDATE_BIT] = 1'b1;
              t_psc_act = t_psc_reg;
              t_reload_act = t_reload_reg;
              for (c = 0; c < MAX_CHANNELS; c++) t_cmp_act[c] = t_cmp_reg[c];
              update_events++;
            end else begin
              // Above the reload value the counter runs on and wraps at 16 bits.
              t_count = t_count + 16'd1;
            end
            for (c = 0; c < MAX_CHANNELS; c++) begin
              if (t_count == t_cmp_act[c]) begin
                t_status[c + 1] = 1'b1;
                compare_hits++;
              end
            end
          end
        end
      end
      ACT_WRITE: begin
        case (it.reg_index)
          REG_CTRL:     t_ctrl = it.write_data[CTRL_W-1:0];
          REG_IRQ_EN:   t_irq_en = it.write_data[IRQ_EN_W-1:0];
          REG_STATUS:   t_status = t_status & it.write_data[STATUS_W-1:0];
          REG_MODE0:    t_mode[0] = it.write_data;
          REG_MODE1:    t_mode[1] = it.write_data;
          REG_OUT_EN:   t_out_en = it.write_data;
          REG_COUNT:    t_count = it.write_data;
          REG_PRESCALE: t_psc_reg = it.write_data;
          REG_RELOAD: begin
            t_reload_reg = it.write_data;
            if (!t_ctrl[CTRL_PRELOAD_BIT]) t_reload_act = it.write_data;
          end
          REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3: begin
            c = int'(it.reg_index) - int'(REG_CMP0);
            cfg = channel_cfg(c);
            t_cmp_reg[c] = it.write_data;
            if (!cfg[MODE_PRELOAD_BIT]) t_cmp_act[c] = it.write_data;
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        case (it.reg_index)
          REG_CTRL:     rd = 16'(t_ctrl);
          REG_IRQ_EN:   rd = 16'(t_irq_en);
          REG_STATUS:   rd = 16'(t_status);
          REG_MODE0:    rd = t_mode[0];
          REG_MODE1:    rd = t_mode[1];
          REG_OUT_EN:   rd = t_out_en;
          REG_COUNT:    rd = t_count;
          REG_PRESCALE: rd = t_psc_reg;
          REG_RELOAD:   rd = t_reload_reg;
          REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3: begin
            rd = t_cmp_reg[int'(it.reg_index) - int'(REG_CMP0)];
          end
          default: rd = '0;
        endcase
      end
      default: ;
    endcase
    // PWM levels reflect the state after this transaction.
    for (c = 0; c < MAX_CHANNELS; c++) begin
      cfg = channel_cfg(c);
      mode = cfg[MODE_MSB:MODE_LSB];
      below = t_count < t_cmp_act[c];
      if (mode == MODE_PWM1) active = below;
      else if (mode == MODE_PWM2) active = !below;
      else active = 1'b0;
      if (t_out_en[OE_STRIDE * c] && (active != t_out_en[OE_STRIDE * c + OE_POLARITY_OFS]))
        lv[c] = 1'b1;
    end
    res.read_data = rd;
    res.pwm_level = lv;
    res.irq = |(t_status & t_irq_en);
  endtask

  // ---------------------------------------------------------------------------
  // Driver. It presents one transaction at a time on the falling edge and holds
  // it steady until the checker below has seen it accepted. After each accepted
  // transaction it may idle for a random number of cycles.
  // ---------------------------------------------------------------------------
  int send_gap_left = 0;

  function automatic int pick_send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items_offered == items_accepted) begin
      // Nothing outstanding: either idle for a while or present the next one.
      if (send_gap_left > 0) begin
        send_gap_left--;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        items_offered++;
        send_gap_left = pick_send_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side readiness. Mostly short holds and long runs of readiness, with a
  // few longer holds. Once, while plenty of traffic is still queued, the
  // receiver holds off long enough for the block to fill and stall its input.
  // ---------------------------------------------------------------------------
  int  ready_hold_left = 0;
  int  ready_run_left = 0;
  int  ready_hold_len = 0;
  bit  long_hold_done = 1'b0;

  always @(negedge clk) begin : ready_ctl
    int r;
    if (rst) begin
      result_ready <= 1'b0;
    end else if (!long_hold_done && items_accepted >= 400 && pending_items.size() > 20) begin
      long_hold_done = 1'b1;
      ready_hold_left = 149;
      ready_hold_len = 1;
      result_ready <= 1'b0;
    end else if (ready_hold_left > 0) begin
      ready_hold_left--;
      ready_hold_len++;
      result_ready <= 1'b0;
    end else if (ready_run_left > 0) begin
      ready_run_left--;
      result_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (ready_hold_len > longest_ready_hold) longest_ready_hold = ready_hold_len;
      if (r < 25) begin
        ready_hold_left = $urandom_range(0, 2);
        ready_hold_len = 1;
        result_ready <= 1'b0;
      end else if (r < 30) begin
        ready_hold_left = $urandom_range(10, 40);
        ready_hold_len = 1;
        result_ready <= 1'b0;
      end else begin
        ready_run_left = $urandom_range(0, 30);
        result_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker. On each rising edge the result transaction is compared with the
  // oldest prediction first, then any accepted input transaction is run through
  // the model and its result queued.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (!rst) begin
      if (result_valid && result_ready) begin
        got = result;
        if (predicted_results.size() == 0) begin
          $error("result transaction with nothing predicted: read_data %h pwm_level %h irq %b",
                 got.read_data, got.pwm_level, got.irq);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            fail_count++;
          end
          if (got.pwm_level !== want.pwm_level) begin
            $error("pwm_level: expected %h, got %h", want.pwm_level, got.pwm_level);
            fail_count++;
          end
          if (got.irq !== want.irq) begin
            $error("irq: expected %b, got %b", want.irq, got.irq);
            fail_count++;
          end
        end
        results_checked++;
      end
      if (item_valid && item_ready) begin
        timer_step(item, want);
        predicted_results.push_back(want);
        items_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  task automatic queue_op(input action_t a, input reg_idx_t r, input logic [15:0] d);
    item_t it;
    it.action = a;
    it.reg_index = r;
    it.write_data = d;
    pending_items.push_back(it);
  endtask

  // Random mode byte, weighted toward the two PWM modes so the outputs toggle.
  function automatic logic [7:0] rand_mode_byte();
    logic [2:0] mode;
    if ($urandom_range(0, 9) < 8) mode = $urandom_range(0, 1) ? MODE_PWM1 : MODE_PWM2;
    else mode = 3'($urandom_range(0, 7));
    return {1'($urandom), mode, 1'($urandom), 3'($urandom)};
  endfunction

  // Hold the sender until everything offered has been accepted and answered.
  task automatic wait_for_drain();
    while (pending_items.size() != 0 || items_offered != items_accepted ||
           predicted_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    int random_items;
    int body_len;
    int reload;
    int i, r;
    logic [15:0] d;

    // Directed opening: reset values, no-op encodings, unmapped registers,
    // preloaded versus immediate compare, an immediate reload, a count above reload that
    // wraps through zero, then an update event and a status clear.
    queue_op(ACT_READ, REG_RELOAD, 16'h0000);
    queue_op(ACT_TICK, REG_CTRL, 16'hFFFF);
    queue_op(action_t'(ACT_UNUSED), reg_idx_t'(4'd15), 16'hFFFF);
    queue_op(ACT_WRITE, reg_idx_t'(4'd13), 16'hFFFF);
    queue_op(ACT_READ, reg_idx_t'(4'd14), 16'h0000);
    queue_op(ACT_WRITE, REG_OUT_EN, 16'hFFFF);
    queue_op(ACT_WRITE, REG_MODE0, 16'h7868);
    queue_op(ACT_WRITE, REG_MODE1, 16'h4870);
    queue_op(ACT_WRITE, REG_CMP0, 16'd3);
    queue_op(ACT_WRITE, REG_CMP2, 16'hFFFF);
    queue_op(ACT_WRITE, REG_RELOAD, 16'd5);
    queue_op(ACT_WRITE, REG_COUNT, 16'hFFFC);
    queue_op(ACT_WRITE, REG_IRQ_EN, 16'h001F);
    queue_op(ACT_WRITE, REG_CTRL, 16'h0081);
    for (i = 0; i < 10; i++) queue_op(ACT_TICK, REG_CTRL, 16'h0000);
    queue_op(ACT_WRITE, REG_STATUS, 16'h0000);
    queue_op(ACT_READ, REG_STATUS, 16'h0000);

    @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait_for_drain();

    // Random phases. Each reprograms the timer, mostly with a short period, runs it
    // mostly on ticks mixed with register traffic and some noise, then lets
    // every result come back before the next phase begins.
    random_items = 0;
    while (random_items < 1600) begin
      r = $urandom_range(0, 99);
      if (r < 80) reload = $urandom_range(1, 24);
      else if (r < 92) reload = 0;
      else reload = 16'hFFFF;
      queue_op(ACT_WRITE, REG_CTRL, {8'($urandom), 7'($urandom), 1'b0});
      queue_op(ACT_WRITE, REG_PRESCALE,
               ($urandom_range(0, 19) == 0) ? 16'($urandom_range(4, 40))
                                            : 16'($urandom_range(0, 3)));
      queue_op(ACT_WRITE, REG_RELOAD, 16'(reload));
      queue_op(ACT_WRITE, REG_COUNT, 16'($urandom_range(0, reload)));
      queue_op(ACT_WRITE, REG_MODE0, {rand_mode_byte(), rand_mode_byte()});
      queue_op(ACT_WRITE, REG_MODE1, {rand_mode_byte(), rand_mode_byte()});
      queue_op(ACT_WRITE, REG_OUT_EN, 16'($urandom));
      for (i = 0; i < MAX_CHANNELS; i++)
        queue_op(ACT_WRITE, reg_idx_t'(4'(int'(REG_CMP0) + i)),
                 16'($urandom_range(0, reload + 1)));
      queue_op(ACT_WRITE, REG_IRQ_EN, 16'($urandom));
      queue_op(ACT_WRITE, REG_STATUS, 16'h0000);
      queue_op(ACT_WRITE, REG_CTRL, {8'($urandom), 7'($urandom), 1'b1});
      random_items += 11 + MAX_CHANNELS;

      body_len = $urandom_range(60, 200);
      for (i = 0; i < body_len; i++) begin
        r = $urandom_range(0, 99);
        d = 16'($urandom);
        if (r < 60) begin
          queue_op(ACT_TICK, reg_idx_t'(4'($urandom)), d);
        end else if (r < 72) begin
          queue_op(ACT_READ, reg_idx_t'(4'($urandom)), d);
        end else if (r < 88) begin
          case ($urandom_range(0, 9))
            0: queue_op(ACT_WRITE, REG_STATUS, d);
            1: queue_op(ACT_WRITE, reg_idx_t'(4'(int'(REG_CMP0) + $urandom_range(0, 3))),
                        16'($urandom_range(0, reload + 2)));
            2: queue_op(ACT_WRITE, REG_RELOAD, 16'($urandom_range(0, 24)));
            3: queue_op(ACT_WRITE, REG_COUNT, 16'($urandom_range(0, reload + 2)));
            4: queue_op(ACT_WRITE, $urandom_range(0, 1) ? REG_MODE1 : REG_MODE0,
                        {rand_mode_byte(), rand_mode_byte()});
            5: queue_op(ACT_WRITE, REG_OUT_EN, d);
            6: queue_op(ACT_WRITE, REG_IRQ_EN, d);
            7: queue_op(ACT_WRITE, REG_PRESCALE, 16'($urandom_range(0, 3)));
            8: queue_op(ACT_WRITE, REG_CTRL,
                        {d[15:1], ($urandom_range(0, 9) != 0) ? 1'b1 : 1'b0});
            default: queue_op(ACT_WRITE, REG_COUNT, 16'($urandom_range(16'hFFF8, 16'hFFFF)));
          endcase
        end else if (r < 94) begin
          // Unconstrained writes, including the unmapped indexes.
          queue_op(ACT_WRITE, reg_idx_t'(4'($urandom)), d);
        end else begin
          queue_op(action_t'(ACT_UNUSED), reg_idx_t'(4'($urandom)), d);
        end
      end
      random_items += body_len;
      wait_for_drain();
    end

    // Keep the clock running so that any stray result would still be caught.
    repeat (8) @(posedge clk);
    $display("Run covered %0d transactions and %0d checked results, with %0d update events,",
             items_accepted, results_checked, update_events);
    $display("%0d compare matches and a longest result hold of %0d cycles.",
             compare_hits, longest_ready_hold);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #20000000;
    $display("Watchdog expired with %0d results still outstanding.", predicted_results.size());
    $display("tb_top failed");
    $finish;
  end

endmodule
